// ===== hdl/rksp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rksp_pkg: shared types and constants for the raster kernel spread block.
// Sizes of the kernel window and raster, field widths, opcodes, register
// indexes, the sequencer states and the structs passed between modules.
// ----------------------------------------------------------------------------
package rksp_pkg;

	// Sizing of the kernel window and of the raster.
	localparam int MAX_RADIUS = 2;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int KSIDE     = 2 * MAX_RADIUS + 1;
	localparam int KSIZE     = KSIDE * KSIDE;
	localparam int KS_W      = $clog2(KSIDE + 1);
	localparam int KIDX_W    = $clog2(KSIZE + 1);
	localparam int ACC_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W    = $clog2(ACC_DEPTH);

	// Item field widths.
	localparam int OPCODE_W = 2;
	localparam int CIDX_W   = 5;
	localparam int COEF_W   = 16;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int PIX_W    = 16;
	localparam int ACC_W    = 36;
	localparam int PROD_W   = COEF_W + PIX_W;
	localparam int SUM_W    = ACC_W + 1;

	// Configuration register widths.
	localparam int RAD_W      = 2;
	localparam int WID_W      = 9;
	localparam int HGT_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Signed window coordinate, wide enough for position plus offset.
	localparam int CRD_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_FIELDS_W = CIDX_W + COEF_W + ROW_W + COL_W + PIX_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_TUSER_W  = OPCODE_W + 1;
	localparam int OUT_TDATA_W = ((ACC_W + 7) / 8) * 8;

	// Saturation limits of the accumulator.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Operation codes.
	localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SCATTER = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} seq_state_t;

	// One input item, unpacked from the stream.
	typedef struct packed {
		logic [OPCODE_W-1:0]     opcode;
		logic [CIDX_W-1:0]       coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic [ROW_W-1:0]        cell_row;
		logic [COL_W-1:0]        cell_col;
		logic signed [PIX_W-1:0] pixel_value;
		logic                    pixel_has_data;
	} item_t;

	// One accumulator access issued by the sequencer.
	typedef struct packed {
		logic                     vld;
		logic                     rd;
		logic                     hit;
		logic [ADDR_W-1:0]        addr;
		logic signed [COEF_W-1:0] coef;
		logic signed [PIX_W-1:0]  pix;
	} issue_t;

	// Accumulator read request.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// Accumulator write request.
	typedef struct packed {
		logic                    we;
		logic [ADDR_W-1:0]       addr;
		logic signed [ACC_W-1:0] data;
	} ram_wr_t;

endpackage
`default_nettype wire

// ===== hdl/rksp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rksp_ram: generic simple dual-port synchronous RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rksp_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rksp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rksp_seq: item sequencer for the raster kernel spread block.
// Holds the configuration and coefficient table, runs the clearing pass
// after reset, accepts items and walks the kernel window of a scatter,
// issuing one accumulator access per in-frame cell.
// ----------------------------------------------------------------------------
module rksp_seq import rksp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration writes.
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Input items.
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire item_t                 item,
	// Output register still holds a result.
	input  wire logic                  out_busy,
	// Accumulator accesses.
	output ram_rd_t                    rd_req,
	output ram_wr_t                    clr_wr,
	output issue_t                     issue_s1
);

	seq_state_t state_q, state_d;

	logic [RAD_W-1:0]  radius_q;
	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;

	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [KS_W-1:0]   dy_q, dy_d;
	logic [KS_W-1:0]   dx_q, dx_d;
	logic [KIDX_W-1:0] k_q, k_d;

	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic signed [PIX_W-1:0] pix_q;

	logic signed [COEF_W-1:0] coef_q [KSIZE];

	issue_t issue_d;
	logic   in_fire;

	logic [RAD_W-1:0]        d_w;
	logic [KS_W-1:0]         lim_w;
	logic [WID_W-1:0]        w_w;
	logic [HGT_W-1:0]        h_w;
	logic signed [CRD_W-1:0] r_s;
	logic signed [CRD_W-1:0] c_s;
	logic                    win_hit;
	logic [ADDR_W-1:0]       win_addr;
	logic                    cell_hit;
	logic [ADDR_W-1:0]       cell_addr;

	// Effective radius and frame size, saturated to the supported maximum.
	always_comb begin
		d_w   = (int'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_q;
		lim_w = KS_W'(d_w) << 1;
		w_w   = (int'(width_q) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : width_q;
		h_w   = (int'(height_q) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : height_q;
	end

	// Position of the current window cell and its frame check.
	always_comb begin
		r_s = $signed(CRD_W'(row_q)) + $signed(CRD_W'(dy_q)) - $signed(CRD_W'(d_w));
		c_s = $signed(CRD_W'(col_q)) + $signed(CRD_W'(dx_q)) - $signed(CRD_W'(d_w));
		win_hit = !r_s[CRD_W-1] && (r_s < $signed(CRD_W'(h_w)))
			&& !c_s[CRD_W-1] && (c_s < $signed(CRD_W'(w_w)));
		win_addr = ADDR_W'(r_s[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_s[COL_W-1:0]);
	end

	// Frame check and address of the cell named by a read item.
	always_comb begin
		cell_hit  = (HGT_W'(row_q) < h_w) && (WID_W'(col_q) < w_w);
		cell_addr = ADDR_W'(row_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_q);
	end

	// Next state, item handshake and access issue.
	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		dy_d     = dy_q;
		dx_d     = dx_q;
		k_d      = k_q;
		issue_d  = '0;
		rd_req   = '0;
		clr_wr   = '0;
		in_ready = 1'b0;
		in_fire  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr_wr.we   = 1'b1;
				clr_wr.addr = clr_q;
				clr_wr.data = '0;
				clr_d       = clr_q + 1'b1;
				if (clr_q == ADDR_W'(ACC_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// The previous access must have left the read stage.
				in_ready = !issue_s1.vld;
				in_fire  = in_valid && in_ready;
				if (in_fire) begin
					case (item.opcode)
						OP_SCATTER: begin
							if (item.pixel_has_data) begin
								state_d = ST_SCAN;
								dy_d    = '0;
								dx_d    = '0;
								k_d     = '0;
							end
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				issue_d.vld  = win_hit;
				issue_d.rd   = 1'b0;
				issue_d.hit  = win_hit;
				issue_d.addr = win_addr;
				issue_d.coef = coef_q[k_q];
				issue_d.pix  = pix_q;
				rd_req.en    = win_hit;
				rd_req.addr  = win_addr;
				// Row-major walk over the window; skipped cells still count.
				k_d = k_q + 1'b1;
				if (dx_q == lim_w) begin
					dx_d = '0;
					if (dy_q == lim_w) begin
						state_d = ST_IDLE;
					end else begin
						dy_d = dy_q + 1'b1;
					end
				end else begin
					dx_d = dx_q + 1'b1;
				end
			end
			ST_READ: begin
				// Wait until the output register can take the result.
				if (!out_busy) begin
					issue_d.vld  = 1'b1;
					issue_d.rd   = 1'b1;
					issue_d.hit  = cell_hit;
					issue_d.addr = cell_addr;
					issue_d.coef = '0;
					issue_d.pix  = pix_q;
					rd_req.en    = cell_hit;
					rd_req.addr  = cell_addr;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			dy_q     <= '0;
			dx_q     <= '0;
			k_q      <= '0;
			issue_s1 <= '0;
			radius_q <= RAD_W'(1);
			width_q  <= WID_W'(256);
			height_q <= HGT_W'(256);
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			dy_q     <= dy_d;
			dx_q     <= dx_d;
			k_q      <= k_d;
			issue_s1 <= issue_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
					CFG_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
					CFG_HEIGHT: height_q <= cfg_data[HGT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Item payload and coefficient table.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q <= item.cell_row;
			col_q <= item.cell_col;
			pix_q <= item.pixel_value;
			if (item.opcode == OP_LOAD && int'(item.coef_index) < KSIZE) begin
				coef_q[KIDX_W'(item.coef_index)] <= item.coef_value;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rksp_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rksp_mac: multiply-accumulate write-back for the accumulator store.
// Multiplies coefficient by pixel value, adds the product to the cell read
// from memory with saturation and writes it back; a read item returns the
// cell through the output register and writes zero.
// ----------------------------------------------------------------------------
module rksp_mac import rksp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire issue_t                  issue_s1,
	input  wire logic [ACC_W-1:0]        rd_data,
	output ram_wr_t                      wb,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [ACC_W-1:0]      out_data
);

	logic                     vld_s2;
	logic                     rd_s2;
	logic                     hit_s2;
	logic [ADDR_W-1:0]        addr_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s2;

	logic                     out_vld_q;
	logic signed [ACC_W-1:0]  out_q;

	logic signed [SUM_W-1:0]  sum;
	logic signed [ACC_W-1:0]  sat;

	// Product stage: the read data arrives together with the issue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= issue_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		rd_s2   <= issue_s1.rd;
		hit_s2  <= issue_s1.hit;
		addr_s2 <= issue_s1.addr;
		prod_s2 <= issue_s1.coef * issue_s1.pix;
		acc_s2  <= $signed(rd_data);
	end

	// Saturating add of the product to the cell.
	always_comb begin
		sum = SUM_W'(acc_s2) + SUM_W'(prod_s2);
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			sat = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end else begin
			sat = sum[ACC_W-1:0];
		end
	end

	// Write back; a read clears the cell.
	always_comb begin
		wb.we   = vld_s2 && hit_s2;
		wb.addr = addr_s2;
		wb.data = rd_s2 ? '0 : sat;
	end

	// Output register for read results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= (out_vld_q && !out_ready) || (vld_s2 && rd_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && rd_s2) begin
			out_q <= hit_s2 ? acc_s2 : '0;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== hdl/raster_kernel_spread_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raster_kernel_spread_top: scatter-form 2D convolution over a raster.
// Top level joining the sequencer, accumulator memory and MAC write-back.
// ----------------------------------------------------------------------------
// After reset the block clears its 65536-entry accumulator memory, one entry
// per cycle, and accepts no item until the clearing pass ends; configuration
// writes are taken at any time. A load or a pixel without data leaves the block
// idle and ready for the next item. A scatter pixel walks the (2d+1) x (2d+1)
// kernel window at one cell per cycle through the single read and single write
// port of the accumulator memory. A read waits while an earlier result has
// not yet been taken. Results wait in an output register while later items
// are accepted.
module raster_kernel_spread_top import rksp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// Input items.
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// coef_index, coef_value, cell_row, cell_col, pixel_value, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode, pixel_has_data
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
	// Result items.
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// cell_sum, zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	item_t                   item;
	ram_rd_t                 rd_req;
	ram_wr_t                 clr_wr;
	ram_wr_t                 wb;
	ram_wr_t                 wr_req;
	issue_t                  issue_s1;
	logic [ACC_W-1:0]        rd_data;
	logic                    out_valid;
	logic signed [ACC_W-1:0] out_data;

	// Unpack the input stream payload.
	always_comb begin
		item.opcode         = s_axis_tuser[OPCODE_W-1:0];
		item.pixel_has_data = s_axis_tuser[OPCODE_W];
		item.coef_index     = s_axis_tdata[CIDX_W-1:0];
		item.coef_value     = $signed(s_axis_tdata[CIDX_W +: COEF_W]);
		item.cell_row       = s_axis_tdata[CIDX_W+COEF_W +: ROW_W];
		item.cell_col       = s_axis_tdata[CIDX_W+COEF_W+ROW_W +: COL_W];
		item.pixel_value    = $signed(s_axis_tdata[CIDX_W+COEF_W+ROW_W+COL_W +: PIX_W]);
	end

	assign cfg_ready = 1'b1;

	rksp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.item     (item),
		.out_busy (out_valid),
		.rd_req   (rd_req),
		.clr_wr   (clr_wr),
		.issue_s1 (issue_s1)
	);

	// The clearing pass and the write-back never overlap.
	assign wr_req = clr_wr.we ? clr_wr : wb;

	rksp_ram #(
		.DEPTH(ACC_DEPTH),
		.WIDTH(ACC_W)
	) u_acc_ram (
		.clk    (clk),
		.wr_en  (wr_req.we),
		.wr_addr(wr_req.addr),
		.wr_data(wr_req.data),
		.rd_en  (rd_req.en),
		.rd_addr(rd_req.addr),
		.rd_data(rd_data)
	);

	rksp_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue_s1 (issue_s1),
		.rd_data  (rd_data),
		.wb       (wb),
		.out_valid(out_valid),
		.out_ready(m_axis_tready),
		.out_data (out_data)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = OUT_TDATA_W'($unsigned(out_data));

endmodule
`default_nettype wire
